>>> hw/rtl/irqc_pkg.sv
// ----------------------------------------------------------------------------
// irqc_pkg
// Shared types, constants and helper functions for the interrupt controller.
// ----------------------------------------------------------------------------
package irqc_pkg;

    localparam int REQ_BITS           = 15;
    localparam int DATA_W             = 16;
    localparam int SRC_W              = 4;
    localparam int NUM_SOURCES        = 16;
    localparam int DELAY_W            = 24;
    localparam int KIND_W             = 3;
    localparam int LEVEL_W            = 3;
    localparam int DELAY_BITS_DEFAULT = 24;

    localparam int SETCLR_BIT    = 15;
    localparam int MASTER_EN_BIT = 14;

    localparam logic [REQ_BITS-1:0] PIN_A_MASK = 15'h0008;
    localparam logic [REQ_BITS-1:0] PIN_B_MASK = 15'h2000;

    localparam logic [REQ_BITS-1:0] LVL6_MASK = 15'h6000;
    localparam logic [REQ_BITS-1:0] LVL5_MASK = 15'h1800;
    localparam logic [REQ_BITS-1:0] LVL4_MASK = 15'h0780;
    localparam logic [REQ_BITS-1:0] LVL3_MASK = 15'h0070;
    localparam logic [REQ_BITS-1:0] LVL2_MASK = 15'h0008;
    localparam logic [REQ_BITS-1:0] LVL1_MASK = 15'h0007;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQ_WRITE = 3'd0,
        KIND_EN_WRITE  = 3'd1,
        KIND_REQ_READ  = 3'd2,
        KIND_SCHEDULE  = 3'd3,
        KIND_TICK      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  data;
        logic [SRC_W-1:0]   source;
        logic [DELAY_W-1:0] delay;
        logic               pin_a_low;
        logic               pin_b_low;
    } in_item_t;

    typedef struct packed {
        logic [REQ_BITS-1:0] request_bits;
        logic [LEVEL_W-1:0]  level;
    } out_item_t;

    typedef struct packed {
        logic                fired_any;
        logic [REQ_BITS-1:0] fire_set;
    } timer_status_t;

    // Set/clear write: bit 15 picks set, bits 14..0 are the mask.
    function automatic logic [REQ_BITS-1:0] apply_word(input logic [REQ_BITS-1:0] cur,
                                                       input logic [DATA_W-1:0]   word);
        logic [REQ_BITS-1:0] mask;
        mask = word[REQ_BITS-1:0];
        if (word[SETCLR_BIT])
            return cur | mask;
        else
            return cur & ~mask;
    endfunction

    function automatic logic [REQ_BITS-1:0] apply_pins(input logic [REQ_BITS-1:0] cur,
                                                       input logic pin_a,
                                                       input logic pin_b);
        logic [REQ_BITS-1:0] r;
        r = cur;
        if (pin_a) r = r | PIN_A_MASK;
        if (pin_b) r = r | PIN_B_MASK;
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] priority_level(input logic [REQ_BITS-1:0] req,
                                                          input logic [REQ_BITS-1:0] en);
        logic [REQ_BITS-1:0] m;
        m = req & en;
        priority if (!en[MASTER_EN_BIT])  return 3'd0;
        else if ((m & LVL6_MASK) != '0)   return 3'd6;
        else if ((m & LVL5_MASK) != '0)   return 3'd5;
        else if ((m & LVL4_MASK) != '0)   return 3'd4;
        else if ((m & LVL3_MASK) != '0)   return 3'd3;
        else if ((m & LVL2_MASK) != '0)   return 3'd2;
        else if ((m & LVL1_MASK) != '0)   return 3'd1;
        else                              return 3'd0;
    endfunction

endpackage

>>> hw/rtl/irqc_timer_bank.sv
// ----------------------------------------------------------------------------
// irqc_timer_bank
// Sixteen countdown timers: schedule with earliest-deadline wins, tick to
// count down and report which sources expire.
// ----------------------------------------------------------------------------
module irqc_timer_bank
    import irqc_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          exec,
    input  in_item_t      item,
    output timer_status_t status
);

    localparam int CMP_W = (DELAY_BITS > DELAY_W) ? DELAY_BITS : DELAY_W;

    logic [NUM_SOURCES-1:0][DELAY_BITS-1:0] cnt_reg;
    logic [NUM_SOURCES-1:0][DELAY_BITS-1:0] cnt_next;
    logic [NUM_SOURCES-1:0]                 expire_vec;

    logic [CMP_W-1:0]      delay_ext;
    logic [CMP_W-1:0]      max_ext;
    logic [CMP_W-1:0]      sat_ext;
    logic [CMP_W-1:0]      cur_ext;
    logic [DELAY_BITS-1:0] cur_cnt;
    logic                  do_tick;
    logic                  do_sched;

    assign do_tick  = exec && (item.kind == KIND_TICK);
    assign delay_ext = CMP_W'(item.delay);
    assign max_ext   = CMP_W'({DELAY_BITS{1'b1}});
    assign sat_ext   = (delay_ext > max_ext) ? max_ext : delay_ext;
    assign cur_cnt   = cnt_reg[item.source];
    assign cur_ext   = CMP_W'(cur_cnt);
    assign do_sched  = exec && (item.kind == KIND_SCHEDULE) && (item.delay != '0)
                       && ((cur_cnt == '0) || (sat_ext < cur_ext));

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            // a count of one reaches zero on this tick
            expire_vec[i] = (cnt_reg[i] == DELAY_BITS'(1));
            if (do_tick && (cnt_reg[i] != '0))
                cnt_next[i] = cnt_reg[i] - DELAY_BITS'(1);
        end
        if (do_sched)
            cnt_next[item.source] = sat_ext[DELAY_BITS-1:0];
    end

    // source fifteen has no request bit but still counts as a firing
    assign status.fired_any = |expire_vec;
    assign status.fire_set  = expire_vec[REQ_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> cnt_reg == $past(cnt_reg))
        else $error("timer state changed without a beat");

endmodule

>>> hw/rtl/irqc_irq_regs.sv
// ----------------------------------------------------------------------------
// irqc_irq_regs
// Request and enable registers with set/clear writes, pin forcing and the
// priority level encoder.
// ----------------------------------------------------------------------------
module irqc_irq_regs
    import irqc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          exec,
    input  in_item_t      item,
    input  timer_status_t tmr,
    output out_item_t     result
);

    logic [REQ_BITS-1:0] request_reg;
    logic [REQ_BITS-1:0] request_next;
    logic [REQ_BITS-1:0] enable_reg;
    logic [REQ_BITS-1:0] enable_next;

    always_comb
    begin
        request_next = request_reg;
        enable_next  = enable_reg;
        if (exec)
        begin
            unique case (kind_t'(item.kind))
                KIND_REQ_WRITE:
                begin
                    request_next = apply_pins(apply_word(request_reg, item.data),
                                              item.pin_a_low, item.pin_b_low);
                end
                KIND_EN_WRITE:
                begin
                    enable_next = apply_word(enable_reg, item.data);
                end
                KIND_TICK:
                begin
                    if (tmr.fired_any)
                        request_next = apply_pins(request_reg | tmr.fire_set,
                                                  item.pin_a_low, item.pin_b_low);
                end
                default:
                begin
                    request_next = request_reg;
                end
            endcase
        end
    end

    assign result.request_bits = request_next;
    assign result.level        = priority_level(request_next, enable_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg <= '0;
            enable_reg  <= '0;
        end
        else
        begin
            request_reg <= request_next;
            enable_reg  <= enable_next;
        end
    end

    a_level_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (result.level != '0) |-> enable_next[MASTER_EN_BIT])
        else $error("level reported with master enable clear");

    a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (item.kind == KIND_REQ_READ)) |=>
            (request_reg == $past(request_reg)) && (enable_reg == $past(enable_reg)))
        else $error("request read modified state");

endmodule

>>> hw/rtl/interrupt_request_controller_core.sv
// ----------------------------------------------------------------------------
// interrupt_request_controller_core
// Sixteen-source interrupt controller with timed sources and priority level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall / item) carries one command per
//   beat: request write, enable write, request read, schedule, or tick.
//   Output channel (result_valid / result_stall / result) returns one beat
//   per command: the request register after the command and the priority
//   level (0..6) of the highest enabled pending request.
//   The path from input beat to result beat runs through the input register,
//   then the state update and level encoder into the result register.
//   Throughput: one beat per cycle while no stalled result is held; the
//   timers count down in parallel, request update and encoder combinational.
//   When result_stall is high with a result held, the next command waits
//   in the input register and item_stall rises only once that is full.
//   Reset clears request, enable and all timers (not armed), and empties
//   both registers.
// ----------------------------------------------------------------------------
module interrupt_request_controller_core
    import irqc_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic          in_valid_reg;
    in_item_t      in_item_reg;
    logic          res_valid_reg;
    out_item_t     res_reg;
    logic          advance;
    timer_status_t tmr_status;
    out_item_t     res_next;

    assign advance    = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    irqc_timer_bank #(
        .DELAY_BITS (DELAY_BITS)
    ) u_timers (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (advance),
        .item   (in_item_reg),
        .status (tmr_status)
    );

    irqc_irq_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (advance),
        .item   (in_item_reg),
        .tmr    (tmr_status),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!item_stall)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            in_item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("processed beat produced no result");

endmodule
